### hdl/mcsw_pkg.sv
// Shared constants, types and a helper function of the modulated comb stereo widener.
package mcsw_pkg;

  // Delay line geometry; the depth must be a power of two.
  localparam int unsigned DELAY_DEPTH = 8192;
  localparam int unsigned AW          = $clog2(DELAY_DEPTH);

  // The sine phase is truncated to this many bits.
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned PHASE_DROP      = 16 - SINE_TABLE_BITS;
  localparam logic [15:0] PHASE_MASK      = 16'hFFFF << PHASE_DROP;

  // Polynomial coefficients of the |sin| approximation, Q16.
  localparam logic [17:0] SIN_C1 = 18'd102944;
  localparam logic [17:0] SIN_C3 = 18'd42334;
  localparam logic [17:0] SIN_C5 = 18'd5223;
  localparam logic [16:0] SIN_ONE = 17'd65536;

  // Sample, coefficient and product widths.
  localparam int unsigned SW   = 24;  // audio sample
  localparam int unsigned MW   = 25;  // mono sum
  localparam int unsigned CW   = 18;  // Q2.16 coefficient
  localparam int unsigned GW   = 17;  // Q1.16 output gain
  localparam int unsigned MA_W = 26;  // multiplier operand A
  localparam int unsigned MB_W = 18;  // multiplier operand B
  localparam int unsigned MP_W = MA_W + MB_W;
  localparam int unsigned LO_W = 22;  // low part of the accumulator in the gain multiply

  // Configuration data and index widths.
  localparam int unsigned CFG_DW = 18;
  localparam int unsigned CFG_IW = 4;

  typedef enum logic [CFG_IW-1:0] {
    REG_DELAY_TIME    = 4'd0,
    REG_MOD_DEPTH     = 4'd1,
    REG_PHASE_STEP    = 4'd2,
    REG_LEFT_DIRECT   = 4'd3,
    REG_LEFT_DELAYED  = 4'd4,
    REG_RIGHT_DIRECT  = 4'd5,
    REG_RIGHT_DELAYED = 4'd6,
    REG_OUTPUT_GAIN   = 4'd7
  } cfg_reg_e;

  // Floor division by 2^32 and saturation to a 24-bit sample.
  function automatic logic signed [SW-1:0] sat_out(input logic signed [63:0] v);
    logic signed [31:0] y;
    logic signed [SW-1:0] r;
    y = v[63:32];
    if (y > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (y < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = y[SW-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/mcsw_if.sv
// Handshake channel interfaces for samples in, samples out and register writes.
interface mcsw_in_if import mcsw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] left_in;
  logic signed [SW-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface mcsw_out_if import mcsw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] left_out;
  logic signed [SW-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface mcsw_cfg_if import mcsw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/mcsw_mul.sv
// Shared signed multiplier with a registered product.
module mcsw_mul import mcsw_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [MA_W-1:0] a_i,
  input  logic signed [MB_W-1:0] b_i,
  output logic signed [MP_W-1:0] p_o
);

  logic signed [MP_W-1:0] p_q;

  // One product per cycle, available on the following cycle.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### hdl/modulated_comb_stereo_widener.sv
// Stereo widener: mono sum into a modulated delay line, mixed back with per-side gains.
// A request runs through the sine, modulation, address, mix and gain steps to the output step.
// A new request waits until the sequencer is idle again; one shared multiplier forms 13 products.
// The block takes a new request while the previous result still waits in the output register.
// Reset: rst_ni clears control state and loads the register defaults; the delay line reads zero.
module modulated_comb_stereo_widener import mcsw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcsw_in_if.sink    sample_i,
  mcsw_out_if.source result_o,
  mcsw_cfg_if.sink   cfg_i
);

  typedef enum logic [15:0] {
    ST_IDLE = 16'b0000_0000_0000_0001,
    ST_SIN0 = 16'b0000_0000_0000_0010,
    ST_SIN1 = 16'b0000_0000_0000_0100,
    ST_SIN2 = 16'b0000_0000_0000_1000,
    ST_SIN3 = 16'b0000_0000_0001_0000,
    ST_MODM = 16'b0000_0000_0010_0000,
    ST_ADDR = 16'b0000_0000_0100_0000,
    ST_LD   = 16'b0000_0000_1000_0000,
    ST_LY   = 16'b0000_0001_0000_0000,
    ST_RD   = 16'b0000_0010_0000_0000,
    ST_RY   = 16'b0000_0100_0000_0000,
    ST_LLO  = 16'b0000_1000_0000_0000,
    ST_LHI  = 16'b0001_0000_0000_0000,
    ST_RLO  = 16'b0010_0000_0000_0000,
    ST_RHI  = 16'b0100_0000_0000_0000,
    ST_OUT  = 16'b1000_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic        [11:0]   delay_time_q;
  logic        [11:0]   mod_depth_q;
  logic        [15:0]   phase_step_q;
  logic signed [CW-1:0] left_direct_q;
  logic signed [CW-1:0] left_delayed_q;
  logic signed [CW-1:0] right_direct_q;
  logic signed [CW-1:0] right_delayed_q;
  logic        [GW-1:0] output_gain_q;

  // Datapath state.
  logic        [AW-1:0]   widx_q;
  logic        [AW:0]     fill_q;
  logic        [15:0]     phase_q;
  logic signed [MW-1:0]   mono_q;
  logic        [16:0]     u2_q;
  logic        [MW-1:0]   rdata_q;
  logic                   hit_q;
  logic signed [MP_W-1:0] accl_q;
  logic signed [MP_W-1:0] accr_q;
  logic signed [63:0]     sum_q;
  logic signed [SW-1:0]   left_res_q;
  logic                   out_valid_q;
  logic signed [SW-1:0]   left_out_q;
  logic signed [SW-1:0]   right_out_q;

  logic        [MW-1:0]   dline_q [DELAY_DEPTH];

  // Multiplier hookup.
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] prod;

  logic                   in_fire;
  logic                   out_free;
  logic signed [MW-1:0]   mono_d;
  logic        [15:0]     phase_qnt;
  logic        [14:0]     half;
  logic        [14:0]     fold;
  logic        [16:0]     u_val;
  logic        [16:0]     prod_q16;
  logic        [16:0]     sin_clamped;
  logic        [AW-1:0]   offset;
  logic        [AW-1:0]   rd_addr;
  logic                   hit_d;
  logic signed [MW-1:0]   past;
  logic signed [63:0]     fin;

  mcsw_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign in_fire        = sample_i.valid && sample_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;

  assign result_o.valid     = out_valid_q;
  assign result_o.left_out  = left_out_q;
  assign result_o.right_out = right_out_q;

  // Mono sum of the incoming pair.
  assign mono_d = {sample_i.left_in[SW-1], sample_i.left_in}
                + {sample_i.right_in[SW-1], sample_i.right_in};

  // Phase quantization and fold into the first quadrant.
  assign phase_qnt = phase_q & PHASE_MASK;
  assign half      = phase_qnt[14:0];
  assign fold      = (half > 15'h4000) ? (15'h4000 - half + 15'h4000) : half;
  assign u_val     = {fold, 2'b00};

  // Q16 view of the previous product, and the clamped sine.
  assign prod_q16    = prod[32:16];
  assign sin_clamped = (prod_q16 > SIN_ONE) ? SIN_ONE : prod_q16;

  // Read address: write index plus base delay plus modulation term, wrapped.
  assign offset  = AW'({1'b0, delay_time_q}
                 + ((mod_depth_q != 12'd0) ? {1'b0, prod_q16[11:0]} : 13'd0));
  assign rd_addr = widx_q + offset;
  // The entry was written by one of the last fill_q writes (newest at widx_q).
  assign hit_d   = ({1'b0, offset} < fill_q);

  assign past = hit_q ? $signed(rdata_q) : '0;

  // Final add of the split gain product.
  assign fin = sum_q + ({{(64-MP_W){prod[MP_W-1]}}, prod} <<< LO_W);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SIN0: begin
        mul_a = MA_W'(u_val);
        mul_b = MB_W'(u_val);
      end
      ST_SIN1: begin
        mul_a = MA_W'(prod_q16);
        mul_b = SIN_C5;
      end
      ST_SIN2: begin
        mul_a = MA_W'(u2_q);
        mul_b = SIN_C3 - {1'b0, prod_q16};
      end
      ST_SIN3: begin
        mul_a = MA_W'(u_val);
        mul_b = SIN_C1 - {1'b0, prod_q16};
      end
      ST_MODM: begin
        mul_a = MA_W'(mod_depth_q);
        mul_b = MB_W'(sin_clamped);
      end
      ST_LD: begin
        mul_a = MA_W'(mono_q);
        mul_b = left_direct_q;
      end
      ST_LY: begin
        mul_a = MA_W'(past);
        mul_b = left_delayed_q;
      end
      ST_RD: begin
        mul_a = MA_W'(mono_q);
        mul_b = right_direct_q;
      end
      ST_RY: begin
        mul_a = MA_W'(past);
        mul_b = right_delayed_q;
      end
      ST_LLO: begin
        mul_a = {{(MA_W-LO_W){1'b0}}, accl_q[LO_W-1:0]};
        mul_b = {1'b0, output_gain_q};
      end
      ST_LHI: begin
        mul_a = {{(MA_W-(MP_W-LO_W)){accl_q[MP_W-1]}}, accl_q[MP_W-1:LO_W]};
        mul_b = {1'b0, output_gain_q};
      end
      ST_RLO: begin
        mul_a = {{(MA_W-LO_W){1'b0}}, accr_q[LO_W-1:0]};
        mul_b = {1'b0, output_gain_q};
      end
      // The right high product stays on the multiplier while the result waits.
      ST_RHI, ST_OUT: begin
        mul_a = {{(MA_W-(MP_W-LO_W)){accr_q[MP_W-1]}}, accr_q[MP_W-1:LO_W]};
        mul_b = {1'b0, output_gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_SIN0;
      ST_SIN0: state_d = ST_SIN1;
      ST_SIN1: state_d = ST_SIN2;
      ST_SIN2: state_d = ST_SIN3;
      ST_SIN3: state_d = ST_MODM;
      ST_MODM: state_d = ST_ADDR;
      ST_ADDR: state_d = ST_LD;
      ST_LD:   state_d = ST_LY;
      ST_LY:   state_d = ST_RD;
      ST_RD:   state_d = ST_RY;
      ST_RY:   state_d = ST_LLO;
      ST_LLO:  state_d = ST_LHI;
      ST_LHI:  state_d = ST_RLO;
      ST_RLO:  state_d = ST_RHI;
      ST_RHI:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration registers and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      widx_q          <= '0;
      fill_q          <= '0;
      phase_q         <= '0;
      out_valid_q     <= 1'b0;
      delay_time_q    <= 12'd914;
      mod_depth_q     <= 12'd0;
      phase_step_q    <= 16'd7;
      left_direct_q   <= 18'sd52429;
      left_delayed_q  <= 18'sd0;
      right_direct_q  <= 18'sd52429;
      right_delayed_q <= 18'sd0;
      output_gain_q   <= 17'd32845;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_DELAY_TIME:    delay_time_q    <= cfg_i.data[11:0];
          REG_MOD_DEPTH:     mod_depth_q     <= cfg_i.data[11:0];
          REG_PHASE_STEP:    phase_step_q    <= cfg_i.data[15:0];
          REG_LEFT_DIRECT:   left_direct_q   <= $signed(cfg_i.data);
          REG_LEFT_DELAYED:  left_delayed_q  <= $signed(cfg_i.data);
          REG_RIGHT_DIRECT:  right_direct_q  <= $signed(cfg_i.data);
          REG_RIGHT_DELAYED: right_delayed_q <= $signed(cfg_i.data);
          REG_OUTPUT_GAIN:   output_gain_q   <= cfg_i.data[GW-1:0];
          default: ;
        endcase
      end
      // Count written entries up to the full depth.
      if (in_fire && (fill_q != (AW+1)'(DELAY_DEPTH))) begin
        fill_q <= fill_q + 1'b1;
      end
      // Phase advance (only with modulation on) and write index step once the read address is formed.
      if (state_q == ST_ADDR) begin
        if (mod_depth_q != 12'd0) begin
          phase_q <= phase_q + phase_step_q;
        end
        widx_q <= (widx_q == '0) ? AW'(DELAY_DEPTH - 1) : widx_q - 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Delay line: write on accept, registered read at the computed address.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dline_q[widx_q] <= mono_d;
    end
    if (state_q == ST_ADDR) begin
      rdata_q <= dline_q[rd_addr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mono_q <= mono_d;
    end
    case (state_q)
      ST_SIN1: u2_q   <= prod_q16;
      ST_ADDR: hit_q  <= hit_d;
      ST_LY:   accl_q <= prod;
      ST_RD:   accl_q <= accl_q - prod;
      ST_RY:   accr_q <= prod;
      ST_LLO:  accr_q <= accr_q - prod;
      ST_LHI:  sum_q  <= {{(64-MP_W){prod[MP_W-1]}}, prod} + 64'sh8000_0000;
      ST_RLO:  left_res_q <= sat_out(fin);
      ST_RHI:  sum_q  <= {{(64-MP_W){prod[MP_W-1]}}, prod} + 64'sh8000_0000;
      ST_OUT: begin
        if (out_free) begin
          left_out_q  <= left_res_q;
          right_out_q <= sat_out(fin);
        end
      end
      default: ;
    endcase
  end

  // The block takes no second request while one is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !sample_i.ready)
    else $error("request accepted while the sequencer was busy");

  // The count of written entries never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (AW+1)'(DELAY_DEPTH))
    else $error("delay line fill count overflow");

  // With modulation off the phase holds across the address step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR) && (mod_depth_q == 12'd0) |=> $stable(phase_q))
    else $error("phase moved with modulation off");

  // A result appears only from the final sequencer step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result valid raised outside the output step");

endmodule
